// ===== hdl/alm_pkg.sv =====
// Shared constants, types and register indexes of the audio level meter.
`default_nettype none

package alm_pkg;

  localparam int SAMPLE_BITS     = 24;
  localparam int COEF_BITS       = 32;
  localparam int EXTRA_FRAC_BITS = 16;
  localparam int LEVEL_BITS      = SAMPLE_BITS + EXTRA_FRAC_BITS;
  localparam int SQ_BITS         = 2 * SAMPLE_BITS - 1;
  localparam int AVG_BITS        = SQ_BITS + EXTRA_FRAC_BITS;
  localparam int HOLD_TIME_BITS  = 24;
  localparam int COUNT_BITS      = 32;
  localparam int CFG_DATA_BITS   = 32;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int PROD_BITS       = 2 * COEF_BITS;
  localparam int ACC_BITS        = COEF_BITS + 1;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_PTR_BITS  = 1;
  localparam int QUEUE_CNT_BITS  = 2;

  localparam logic [COEF_BITS-1:0]      SHORT_AVG_COEF_RST = 32'd298241;
  localparam logic [COEF_BITS-1:0]      LONG_AVG_COEF_RST  = 32'd2983;
  localparam logic [COEF_BITS-1:0]      MAX_DECAY_RST      = 32'd4294669055;
  localparam logic [COEF_BITS-1:0]      HOLD_DECAY_RST     = 32'd4294907645;
  localparam logic [HOLD_TIME_BITS-1:0] HOLD_TIME_RST      = 24'd48000;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SHORT_AVG_COEF = 3'd0,
    CFG_LONG_AVG_COEF  = 3'd1,
    CFG_MAX_DECAY      = 3'd2,
    CFG_HOLD_DECAY     = 3'd3,
    CFG_HOLD_TIME      = 3'd4
  } alm_cfg_index_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] mag;
    logic                   clip;
  } alm_item_t;

endpackage

`default_nettype wire

// ===== hdl/audio_level_meter_core.sv =====
// Top level of the audio level meter: sample queue and level sequencer.
//
//   Port group  Direction  Handshake        Payload
//   in_         input      valid / ready    audio_in, signed sample
//   out_        output     valid / ready    hold, max, mean squares, counts
//   cfg_        input      write enable     register index and write data
//
// The back end steps through each sample: the idle step that pops the queue,
// nine product steps through the one shared 32x32 multiplier, then ST_L_FIN
// that finishes the long-term average and ST_WB that writes back.
// The two-entry queue keeps taking samples, until full, while a result waits unread.
// Reset is synchronous and active low and restores the register defaults.
`default_nettype none

module audio_level_meter_core
  import alm_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [SAMPLE_BITS-1:0]    in_audio_in,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [SAMPLE_BITS-1:0]         out_hold_level,
  output logic [SAMPLE_BITS-1:0]         out_max_level,
  output logic [SQ_BITS-1:0]             out_short_mean_square,
  output logic [SQ_BITS-1:0]             out_long_mean_square,
  output logic [COUNT_BITS-1:0]          out_clip_count,
  output logic [COUNT_BITS-1:0]          out_sample_count,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

  alm_item_t item;
  logic      item_valid;
  logic      item_ready;

  alm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_audio_in (in_audio_in),
    .item        (item),
    .item_valid  (item_valid),
    .item_ready  (item_ready)
  );

  alm_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .item                  (item),
    .item_valid            (item_valid),
    .item_ready            (item_ready),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_hold_level        (out_hold_level),
    .out_max_level         (out_max_level),
    .out_short_mean_square (out_short_mean_square),
    .out_long_mean_square  (out_long_mean_square),
    .out_clip_count        (out_clip_count),
    .out_sample_count      (out_sample_count)
  );

endmodule

`default_nettype wire

// ===== hdl/alm_mul.sv =====
// Registered unsigned multiplier shared by all product steps of the meter.
`default_nettype none

module alm_mul
  import alm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic [COEF_BITS-1:0] mul_a,
  input  wire logic [COEF_BITS-1:0] mul_b,
  output logic      [PROD_BITS-1:0] prod
);

  logic [PROD_BITS-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// ===== hdl/alm_front.sv =====
// Input stage: takes samples, forms magnitude and clip flag, and queues them.
`default_nettype none

module alm_front
  import alm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] in_audio_in,
  output alm_item_t                   item,
  output logic                        item_valid,
  input  wire logic                   item_ready
);

  alm_item_t                 queue_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_r;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr_r;
  logic [QUEUE_CNT_BITS-1:0] count_r;
  logic [QUEUE_CNT_BITS-1:0] count_nxt;
  logic                      push;
  logic                      pop;
  alm_item_t                 classified;

  always_comb begin
    if (in_audio_in[SAMPLE_BITS-1]) begin
      classified.mag = ~in_audio_in + {{(SAMPLE_BITS-1){1'b0}}, 1'b1};
    end else begin
      classified.mag = in_audio_in;
    end
    classified.clip = classified.mag[SAMPLE_BITS-1] | classified.mag[SAMPLE_BITS-2];
  end

  assign in_ready   = (count_r != QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign item_valid = (count_r != '0);
  assign item       = queue_r[rd_ptr_r];
  assign push       = in_valid && in_ready;
  assign pop        = item_valid && item_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= classified;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/alm_back.sv =====
// Level sequencer: holds the meter state and updates it through one multiplier.
`default_nettype none

module alm_back
  import alm_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  input  wire alm_item_t                 item,
  input  wire logic                      item_valid,
  output logic                           item_ready,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [SAMPLE_BITS-1:0]         out_hold_level,
  output logic [SAMPLE_BITS-1:0]         out_max_level,
  output logic [SQ_BITS-1:0]             out_short_mean_square,
  output logic [SQ_BITS-1:0]             out_long_mean_square,
  output logic [COUNT_BITS-1:0]          out_clip_count,
  output logic [COUNT_BITS-1:0]          out_sample_count
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_H_LO,
    ST_H_HI,
    ST_M_LO,
    ST_M_HI,
    ST_S_LO,
    ST_S_HI,
    ST_L_LO,
    ST_L_HI,
    ST_L_FIN,
    ST_WB
  } state_t;

  state_t state_r;

  logic [COEF_BITS-1:0]      short_coef_r;
  logic [COEF_BITS-1:0]      long_coef_r;
  logic [COEF_BITS-1:0]      max_decay_r;
  logic [COEF_BITS-1:0]      hold_decay_r;
  logic [HOLD_TIME_BITS-1:0] hold_time_r;

  logic [LEVEL_BITS-1:0]     hold_value_r;
  logic [HOLD_TIME_BITS-1:0] hold_counter_r;
  logic [LEVEL_BITS-1:0]     max_value_r;
  logic [AVG_BITS-1:0]       short_avg_r;
  logic [AVG_BITS-1:0]       long_avg_r;
  logic [COUNT_BITS-1:0]     clip_total_r;
  logic [COUNT_BITS-1:0]     seen_total_r;
  logic                      out_valid_r;

  logic [SAMPLE_BITS-1:0]    mag_r;
  logic                      clip_r;
  logic                      hold_peak_r;
  logic                      max_peak_r;
  logic [AVG_BITS-1:0]       sq_r;
  logic                      s_neg_r;
  logic [AVG_BITS-1:0]       s_diff_r;
  logic                      l_neg_r;
  logic [AVG_BITS-1:0]       l_diff_r;
  logic [ACC_BITS-1:0]       acc_r;
  logic [AVG_BITS-1:0]       q_r;

  logic [COEF_BITS-1:0]      mul_a;
  logic [COEF_BITS-1:0]      mul_b;
  logic [PROD_BITS-1:0]      prod;
  logic [LEVEL_BITS-1:0]     lvl;
  logic [COEF_BITS-1:0]      rnd_mask;
  logic [PROD_BITS:0]        lo_sum;
  logic [PROD_BITS-1:0]      hi_sum;
  logic                      start;

  alm_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  assign lvl        = {mag_r, {EXTRA_FRAC_BITS{1'b0}}};
  assign item_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign start      = item_valid && item_ready;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQ: begin
        mul_a = {{(COEF_BITS-SAMPLE_BITS){1'b0}}, mag_r};
        mul_b = {{(COEF_BITS-SAMPLE_BITS){1'b0}}, mag_r};
      end
      ST_H_LO: begin
        mul_a = hold_value_r[COEF_BITS-1:0];
        mul_b = hold_decay_r;
      end
      ST_H_HI: begin
        mul_a = {{(2*COEF_BITS-LEVEL_BITS){1'b0}}, hold_value_r[LEVEL_BITS-1:COEF_BITS]};
        mul_b = hold_decay_r;
      end
      ST_M_LO: begin
        mul_a = max_value_r[COEF_BITS-1:0];
        mul_b = max_decay_r;
      end
      ST_M_HI: begin
        mul_a = {{(2*COEF_BITS-LEVEL_BITS){1'b0}}, max_value_r[LEVEL_BITS-1:COEF_BITS]};
        mul_b = max_decay_r;
      end
      ST_S_LO: begin
        mul_a = s_diff_r[COEF_BITS-1:0];
        mul_b = short_coef_r;
      end
      ST_S_HI: begin
        mul_a = {{(2*COEF_BITS-AVG_BITS){1'b0}}, s_diff_r[AVG_BITS-1:COEF_BITS]};
        mul_b = short_coef_r;
      end
      ST_L_LO: begin
        mul_a = l_diff_r[COEF_BITS-1:0];
        mul_b = long_coef_r;
      end
      ST_L_HI: begin
        mul_a = {{(2*COEF_BITS-AVG_BITS){1'b0}}, l_diff_r[AVG_BITS-1:COEF_BITS]};
        mul_b = long_coef_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // A falling average rounds its step up, which adds all ones below the cut.
  always_comb begin
    rnd_mask = '0;
    if ((state_r == ST_S_HI && s_neg_r) || (state_r == ST_L_HI && l_neg_r)) begin
      rnd_mask = '1;
    end
    lo_sum = {1'b0, prod} + {{(ACC_BITS){1'b0}}, rnd_mask};
    hi_sum = prod + {{(PROD_BITS-ACC_BITS){1'b0}}, acc_r};
  end

  always_ff @(posedge clk) begin
    acc_r <= lo_sum[PROD_BITS:COEF_BITS];
    if (start) begin
      mag_r  <= item.mag;
      clip_r <= item.clip;
    end
    case (state_r)
      ST_SQ: begin
        hold_peak_r <= (hold_value_r < lvl);
        max_peak_r  <= (max_value_r < lvl);
      end
      ST_H_LO: begin
        sq_r <= {prod[SQ_BITS-1:0], {EXTRA_FRAC_BITS{1'b0}}};
      end
      ST_H_HI: begin
        s_neg_r <= (sq_r < short_avg_r);
        if (sq_r < short_avg_r) begin
          s_diff_r <= short_avg_r - sq_r;
        end else begin
          s_diff_r <= sq_r - short_avg_r;
        end
      end
      ST_M_LO: begin
        l_neg_r <= (sq_r < long_avg_r);
        if (sq_r < long_avg_r) begin
          l_diff_r <= long_avg_r - sq_r;
        end else begin
          l_diff_r <= sq_r - long_avg_r;
        end
      end
      ST_L_LO: begin
        q_r <= hi_sum[AVG_BITS-1:0];
      end
      ST_L_FIN: begin
        q_r <= hi_sum[AVG_BITS-1:0];
      end
      default: begin
      end
    endcase

    if (!rst_n) begin
      state_r        <= ST_IDLE;
      short_coef_r   <= SHORT_AVG_COEF_RST;
      long_coef_r    <= LONG_AVG_COEF_RST;
      max_decay_r    <= MAX_DECAY_RST;
      hold_decay_r   <= HOLD_DECAY_RST;
      hold_time_r    <= HOLD_TIME_RST;
      hold_value_r   <= '0;
      hold_counter_r <= '0;
      max_value_r    <= '0;
      short_avg_r    <= '0;
      long_avg_r     <= '0;
      clip_total_r   <= '0;
      seen_total_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (alm_cfg_index_t'(cfg_index))
          CFG_SHORT_AVG_COEF: short_coef_r <= cfg_wdata[COEF_BITS-1:0];
          CFG_LONG_AVG_COEF:  long_coef_r  <= cfg_wdata[COEF_BITS-1:0];
          CFG_MAX_DECAY:      max_decay_r  <= cfg_wdata[COEF_BITS-1:0];
          CFG_HOLD_DECAY:     hold_decay_r <= cfg_wdata[COEF_BITS-1:0];
          CFG_HOLD_TIME:      hold_time_r  <= cfg_wdata[HOLD_TIME_BITS-1:0];
          default: begin
          end
        endcase
      end

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (seen_total_r != '1) begin
            seen_total_r <= seen_total_r + 1'b1;
          end
          if (clip_r && clip_total_r != '1) begin
            clip_total_r <= clip_total_r + 1'b1;
          end
          state_r <= ST_H_LO;
        end
        ST_H_LO: state_r <= ST_H_HI;
        ST_H_HI: state_r <= ST_M_LO;
        ST_M_LO: begin
          if (hold_peak_r) begin
            hold_value_r   <= lvl;
            hold_counter_r <= hold_time_r;
          end else if (hold_counter_r != '0) begin
            hold_counter_r <= hold_counter_r - 1'b1;
          end else begin
            hold_value_r <= hi_sum[LEVEL_BITS-1:0];
          end
          state_r <= ST_M_HI;
        end
        ST_M_HI: state_r <= ST_S_LO;
        ST_S_LO: begin
          if (max_peak_r) begin
            max_value_r <= lvl;
          end else begin
            max_value_r <= hi_sum[LEVEL_BITS-1:0];
          end
          state_r <= ST_S_HI;
        end
        ST_S_HI: state_r <= ST_L_LO;
        ST_L_LO: state_r <= ST_L_HI;
        ST_L_HI: begin
          if (s_neg_r) begin
            short_avg_r <= short_avg_r - q_r;
          end else begin
            short_avg_r <= short_avg_r + q_r;
          end
          state_r <= ST_L_FIN;
        end
        ST_L_FIN: state_r <= ST_WB;
        ST_WB: begin
          if (l_neg_r) begin
            long_avg_r <= long_avg_r - q_r;
          end else begin
            long_avg_r <= long_avg_r + q_r;
          end
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_hold_level        = hold_value_r[LEVEL_BITS-1:EXTRA_FRAC_BITS];
  assign out_max_level         = max_value_r[LEVEL_BITS-1:EXTRA_FRAC_BITS];
  assign out_short_mean_square = short_avg_r[AVG_BITS-1:EXTRA_FRAC_BITS];
  assign out_long_mean_square  = long_avg_r[AVG_BITS-1:EXTRA_FRAC_BITS];
  assign out_clip_count        = clip_total_r;
  assign out_sample_count      = seen_total_r;

  a_result_from_writeback: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_WB))
    else $error("Result raised outside the write-back step.");

  a_writeback_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB) |-> !out_valid_r)
    else $error("Write-back while the previous result is still pending.");

  a_clip_within_seen: assert property (@(posedge clk) disable iff (!rst_n)
    clip_total_r <= seen_total_r)
    else $error("Clip count exceeds sample count.");

  a_levels_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (max_value_r <= {1'b1, {(LEVEL_BITS-1){1'b0}}}) &&
    (hold_value_r <= {1'b1, {(LEVEL_BITS-1){1'b0}}}))
    else $error("Level above the largest sample magnitude.");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the audio level meter core with its own level predictor.
`timescale 1ns / 100ps

module tb_top;
  import alm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 24;
  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = SAMPLE_BITS'(1 << (SAMPLE_BITS - 2));

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] hold_level;
    logic [SAMPLE_BITS-1:0] max_level;
    logic [SQ_BITS-1:0]     short_ms;
    logic [SQ_BITS-1:0]     long_ms;
    logic [COUNT_BITS-1:0]  clips;
    logic [COUNT_BITS-1:0]  samples;
  } levels_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SAMPLE_BITS-1:0] in_audio_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SAMPLE_BITS-1:0] out_hold_level;
  logic [SAMPLE_BITS-1:0] out_max_level;
  logic [SQ_BITS-1:0] out_short_mean_square;
  logic [SQ_BITS-1:0] out_long_mean_square;
  logic [COUNT_BITS-1:0] out_clip_count;
  logic [COUNT_BITS-1:0] out_sample_count;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  audio_level_meter_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_audio_in(in_audio_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_hold_level(out_hold_level),
    .out_max_level(out_max_level),
    .out_short_mean_square(out_short_mean_square),
    .out_long_mean_square(out_long_mean_square),
    .out_clip_count(out_clip_count),
    .out_sample_count(out_sample_count),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  logic [COEF_BITS-1:0] short_coef, long_coef, max_coef, hold_coef;
  logic [HOLD_TIME_BITS-1:0] hold_samples;
  logic [LEVEL_BITS-1:0] hold_lvl, max_lvl;
  logic [HOLD_TIME_BITS-1:0] hold_left;
  logic [AVG_BITS-1:0] short_acc, long_acc;
  logic [COUNT_BITS-1:0] clip_tally, sample_tally;

  levels_t pending_levels[$];
  levels_t oldest;
  int mismatches = 0;
  bit idling_on = 1'b1;
  int hold_request = 0;
  int ready_hold_left = 0;
  int ready_stall_left = 0;
  int quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [LEVEL_BITS-1:0] decayed(input logic [LEVEL_BITS-1:0] lvl,
                                                    input logic [COEF_BITS-1:0] k);
    logic [LEVEL_BITS+COEF_BITS-1:0] prod;
    prod = (LEVEL_BITS+COEF_BITS)'(lvl) * (LEVEL_BITS+COEF_BITS)'(k);
    return prod[LEVEL_BITS+COEF_BITS-1:COEF_BITS];
  endfunction

  function automatic logic [AVG_BITS-1:0] averaged(input logic [AVG_BITS-1:0] avg,
                                                   input logic [COEF_BITS-1:0] k,
                                                   input logic [AVG_BITS-1:0] sq);
    logic [AVG_BITS+COEF_BITS-1:0] prod;
    if (sq >= avg) begin
      prod = (AVG_BITS+COEF_BITS)'(sq - avg) * (AVG_BITS+COEF_BITS)'(k);
      return avg + prod[AVG_BITS+COEF_BITS-1:COEF_BITS];
    end
    // A falling average rounds its step toward minus infinity.
    prod = (AVG_BITS+COEF_BITS)'(avg - sq) * (AVG_BITS+COEF_BITS)'(k) +
           (AVG_BITS+COEF_BITS)'({COEF_BITS{1'b1}});
    return avg - prod[AVG_BITS+COEF_BITS-1:COEF_BITS];
  endfunction

  function automatic void reset_levels();
    short_coef = SHORT_AVG_COEF_RST;
    long_coef = LONG_AVG_COEF_RST;
    max_coef = MAX_DECAY_RST;
    hold_coef = HOLD_DECAY_RST;
    hold_samples = HOLD_TIME_RST;
    hold_lvl = '0;
    max_lvl = '0;
    hold_left = '0;
    short_acc = '0;
    long_acc = '0;
    clip_tally = '0;
    sample_tally = '0;
  endfunction

  function automatic levels_t next_levels(input logic [SAMPLE_BITS-1:0] sample);
    logic [SAMPLE_BITS-1:0] mag;
    logic [LEVEL_BITS-1:0] lvl;
    logic [AVG_BITS-1:0] sq;
    levels_t res;
    mag = sample[SAMPLE_BITS-1] ? -sample : sample;
    lvl = {mag, {EXTRA_FRAC_BITS{1'b0}}};
    sq = AVG_BITS'(mag) * AVG_BITS'(mag);
    sq = sq << EXTRA_FRAC_BITS;
    if (mag >= FULL_SCALE && clip_tally != '1) clip_tally = clip_tally + 1'b1;
    if (sample_tally != '1) sample_tally = sample_tally + 1'b1;
    if (hold_lvl < lvl) begin
      hold_lvl = lvl;
      hold_left = hold_samples;
    end else if (hold_left != '0) begin
      hold_left = hold_left - 1'b1;
    end else begin
      hold_lvl = decayed(hold_lvl, hold_coef);
    end
    if (max_lvl < lvl) max_lvl = lvl;
    else max_lvl = decayed(max_lvl, max_coef);
    short_acc = averaged(short_acc, short_coef, sq);
    long_acc = averaged(long_acc, long_coef, sq);
    res.hold_level = hold_lvl[LEVEL_BITS-1:EXTRA_FRAC_BITS];
    res.max_level = max_lvl[LEVEL_BITS-1:EXTRA_FRAC_BITS];
    res.short_ms = short_acc[AVG_BITS-1:EXTRA_FRAC_BITS];
    res.long_ms = long_acc[AVG_BITS-1:EXTRA_FRAC_BITS];
    res.clips = clip_tally;
    res.samples = sample_tally;
    return res;
  endfunction

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s mismatch: expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  // Result checker and receiver-side stall control.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_levels.size() == 0) begin
        mismatches++;
        $display("%0t unexpected transaction: expected none actual hold %0d sample_count %0d",
                 $time, out_hold_level, out_sample_count);
      end else begin
        oldest = pending_levels.pop_front();
        check_field("hold_level", 64'(oldest.hold_level), 64'(out_hold_level));
        check_field("max_level", 64'(oldest.max_level), 64'(out_max_level));
        check_field("short_mean_square", 64'(oldest.short_ms),
                    64'(out_short_mean_square));
        check_field("long_mean_square", 64'(oldest.long_ms),
                    64'(out_long_mean_square));
        check_field("clip_count", 64'(oldest.clips), 64'(out_clip_count));
        check_field("sample_count", 64'(oldest.samples), 64'(out_sample_count));
      end
    end
    if (hold_request != 0) begin
      ready_hold_left = hold_request;
      hold_request <= 0;
    end
    if (ready_hold_left != 0) begin
      ready_hold_left--;
      out_ready <= 1'b0;
    end else if (ready_stall_left != 0) begin
      ready_stall_left--;
      out_ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      ready_stall_left = $urandom_range(1, 12) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog expired with %0d results outstanding", $time,
               pending_levels.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic send_sample(input int s);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_audio_in <= s[SAMPLE_BITS-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_levels.push_back(next_levels(s[SAMPLE_BITS-1:0]));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input alm_cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_SHORT_AVG_COEF: short_coef = data[COEF_BITS-1:0];
      CFG_LONG_AVG_COEF:  long_coef = data[COEF_BITS-1:0];
      CFG_MAX_DECAY:      max_coef = data[COEF_BITS-1:0];
      CFG_HOLD_DECAY:     hold_coef = data[COEF_BITS-1:0];
      CFG_HOLD_TIME:      hold_samples = data[HOLD_TIME_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [CFG_DATA_BITS-1:0] short_k,
                           input logic [CFG_DATA_BITS-1:0] long_k,
                           input logic [CFG_DATA_BITS-1:0] max_k,
                           input logic [CFG_DATA_BITS-1:0] hold_k,
                           input logic [CFG_DATA_BITS-1:0] hold_n);
    wait_drained();
    write_reg(CFG_SHORT_AVG_COEF, short_k);
    write_reg(CFG_LONG_AVG_COEF, long_k);
    write_reg(CFG_MAX_DECAY, max_k);
    write_reg(CFG_HOLD_DECAY, hold_k);
    write_reg(CFG_HOLD_TIME, hold_n);
    end_writes();
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] pick_coef();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return $urandom;
      3: return 32'hFFFF_0000 | $urandom_range(0, 65535);
      default: return $urandom_range(0, 1 << 20);
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_hold_time();
    logic [HOLD_TIME_BITS-1:0] n;
    case ($urandom_range(0, 4))
      0: n = '0;
      1: n = '1;
      2: n = HOLD_TIME_BITS'($urandom_range(1, 16));
      default: n = HOLD_TIME_BITS'($urandom_range(0, 200));
    endcase
    return {8'($urandom_range(0, 255)), n};
  endfunction

  function automatic int pick_sample(input int style, input int pos);
    int v;
    case (style)
      0: v = $urandom;
      1: v = int'($urandom_range(0, 2000)) - 1000;
      2: begin
        v = int'(FULL_SCALE) + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1) != 0) v = -v;
      end
      3: case ($urandom_range(0, 3))
        0: v = 8388607;
        1: v = -8388608;
        2: v = -8388607;
        default: v = 0;
      endcase
      default: v = (pos < 2) ? int'($urandom) : 0;
    endcase
    return v;
  endfunction

  task automatic test_default_levels();
    send_sample(1000);
    send_sample(-2000);
    send_sample(0);
    send_sample(500);
  endtask

  task automatic test_sample_extremes();
    write_all(32'h4000_0000, 32'h0100_0000, 32'hC000_0000, 32'h8000_0000, 32'd3);
    send_sample(8388607);
    send_sample(-8388608);
    send_sample(4194304);
    send_sample(4194303);
    send_sample(-4194304);
    send_sample(-4194303);
    send_sample(-1);
    send_sample(1);
    repeat (5) send_sample(0);
  endtask

  task automatic test_zero_hold_time();
    write_all(32'h0001_0000, 32'h0000_1000, 32'hFFF0_0000, 32'hF000_0000, 32'hFF00_0000);
    send_sample(100000);
    send_sample(0);
    send_sample(0);
    send_sample(50000);
  endtask

  task automatic test_coef_extremes();
    write_all('0, '0, '0, '0, '0);
    send_sample(3000000);
    send_sample(-3000000);
    write_all('1, '1, '1, '1, '1);
    send_sample(3000000);
    send_sample(0);
    send_sample(-8388608);
  endtask

  task automatic test_random_phases();
    int style;
    for (int p = 0; p < 5; p++) begin
      write_all(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_hold_time());
      style = 0;
      for (int i = 0; i < 90; i++) begin
        if (i % 8 == 0) style = $urandom_range(0, 4);
        send_sample(pick_sample(style, i % 8));
      end
    end
  endtask

  task automatic test_output_backpressure();
    write_all(pick_coef(), pick_coef(), pick_coef(), pick_coef(), 32'd5);
    idling_on <= 1'b0;
    hold_request <= 300;
    for (int i = 0; i < 20; i++) send_sample(pick_sample(0, i));
    idling_on <= 1'b1;
  endtask

  task automatic test_no_idle_run();
    int style;
    write_all(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_hold_time());
    idling_on <= 1'b0;
    style = 0;
    for (int i = 0; i < 80; i++) begin
      if (i % 8 == 0) style = $urandom_range(0, 4);
      send_sample(pick_sample(style, i % 8));
    end
  endtask

  initial begin
    reset_levels();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_levels();
    test_sample_extremes();
    test_zero_hold_time();
    test_coef_extremes();
    test_random_phases();
    test_output_backpressure();
    test_no_idle_run();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
